@@ rtl/mcts_pkg.sv @@
`timescale 1ns / 1ps
package mcts_pkg;

    localparam int TASK_SLOTS = 64;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);

    localparam int ACTION_W   = 3;
    localparam int QUANTUM_W  = 8;
    localparam int SCAN_W     = 6;
    localparam int ID_W       = 16;
    localparam int SLOT_OUT_W = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(2);
    localparam logic [SCAN_W-1:0]    SCAN_RESET    = SCAN_W'(2);
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

    localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_YIELD   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_EXIT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PREEMPT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN    = 1'b1;

    typedef struct packed {
        logic [QUANTUM_W-1:0] counter;
        logic [ID_W-1:0]      id;
    } slot_word_t;

    typedef struct packed {
        logic              clear;
        logic              eval;
        logic              cand;
        logic              in_range;
        logic [SLOT_W-1:0] idx;
    } scan_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_APPLY = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

endpackage

@@ rtl/mcts_in_if.sv @@
`timescale 1ns / 1ps
interface mcts_in_if;
    import mcts_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                preempt_value;

    modport source (output valid, output action, output preempt_value, input ready);
    modport sink (input valid, input action, input preempt_value, output ready);
endinterface

@@ rtl/mcts_out_if.sv @@
`timescale 1ns / 1ps
interface mcts_out_if;
    import mcts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SLOT_OUT_W-1:0] current_slot;
    logic [ID_W-1:0]       current_id;
    logic                  switched;
    logic [ID_W-1:0]       created_id;
    logic [COUNT_W-1:0]    runnable_count;

    modport source (output valid, output current_slot, output current_id, output switched,
                    output created_id, output runnable_count, input ready);
    modport sink (input valid, input current_slot, input current_id, input switched,
                  input created_id, input runnable_count, output ready);
endinterface

@@ rtl/mcts_table.sv @@
`timescale 1ns / 1ps
module mcts_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [mcts_pkg::SLOT_W-1:0] wr_addr,
    input  mcts_pkg::slot_word_t        wr_data,
    input  logic [mcts_pkg::SLOT_W-1:0] rd_addr,
    output mcts_pkg::slot_word_t        rd_data
);
    import mcts_pkg::*;

    slot_word_t              mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]   init_reg;
    slot_word_t              rd_raw_reg;
    logic                    rd_init_reg;

    // never-written entries read as zero counter and zero id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
        end
        else if (wr_en)
        begin
            init_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg  <= mem[rd_addr];
        rd_init_reg <= init_reg[rd_addr];
    end

    assign rd_data = rd_init_reg ? rd_raw_reg : '0;
endmodule

@@ rtl/mcts_scan.sv @@
`timescale 1ns / 1ps
module mcts_scan (
    input  logic                         clk,
    input  mcts_pkg::scan_ctl_t          ctl,
    input  mcts_pkg::slot_word_t         word,
    output logic [mcts_pkg::SLOT_W-1:0]  best_slot,
    output logic [mcts_pkg::ID_W-1:0]    best_id,
    output logic [mcts_pkg::COUNT_W-1:0] count
);
    import mcts_pkg::*;

    logic [QUANTUM_W-1:0] top_reg;
    logic [SLOT_W-1:0]    best_reg;
    logic [ID_W-1:0]      best_id_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 better;

    // strict compare keeps the lowest slot on a tie
    assign better = ctl.cand && ctl.in_range && (word.counter > top_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            top_reg   <= '0;
            best_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctl.eval)
        begin
            // slot 0 is the fallback choice
            if (ctl.idx == '0)
            begin
                best_id_reg <= word.id;
            end
            if (ctl.cand && count_reg != COUNT_MAX)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (better)
            begin
                top_reg     <= word.counter;
                best_reg    <= ctl.idx;
                best_id_reg <= word.id;
            end
        end
    end

    assign best_slot = best_reg;
    assign best_id   = best_id_reg;
    assign count     = count_reg;
endmodule

@@ rtl/max_counter_task_scheduler.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// req       in   valid/ready   action[2:0], preempt_value
// rsp       out  valid/ready   current_slot[5:0], current_id[15:0], switched,
//                              created_id[15:0], runnable_count[6:0]
// cfg       in   cfg_we        cfg_index (0 quantum, 1 scan start), cfg_data[7:0]
//
// a beat is taken in idle, then come the apply state, reads of all 64 slots feeding one shared
// compare and count unit, a drain of the last read and the commit state; rsp.valid is registered
// in commit, and no new beat is taken until the block is back in idle
// req.ready is high only while idle; the commit state holds while rsp is stalled
// reset restores flags, pointers and config; table words read as zero until written
module max_counter_task_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    mcts_in_if.sink                        req,
    mcts_out_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [mcts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcts_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mcts_pkg::*;

    state_t                state_reg, state_next;
    logic [QUANTUM_W-1:0]  quantum_reg;
    logic [SCAN_W-1:0]     scan_start_reg;
    logic [TASK_SLOTS-1:0] valid_reg, valid_next;
    logic [TASK_SLOTS-1:0] running_reg, running_next;
    logic [TASK_SLOTS-1:0] preempt_reg, preempt_next;
    logic [SLOT_W-1:0]     running_slot_reg, running_slot_next;
    logic [SLOT_W-1:0]     insert_slot_reg, insert_slot_next;
    logic [ID_W-1:0]       next_id_reg, next_id_next;
    logic [ACTION_W-1:0]   action_reg;
    logic                  pv_reg;
    logic                  do_pick_reg, do_pick_next;
    logic [ID_W-1:0]       created_reg, created_next;
    logic [SLOT_W:0]       scan_idx_reg;
    logic                  eval_vld_reg;
    logic [SLOT_W-1:0]     eval_idx_reg;
    logic [ID_W-1:0]       run_id_reg;

    logic                  rsp_valid_reg;
    logic [SLOT_OUT_W-1:0] rsp_slot_reg;
    logic [ID_W-1:0]       rsp_id_reg;
    logic                  rsp_switched_reg;
    logic [ID_W-1:0]       rsp_created_reg;
    logic [COUNT_W-1:0]    rsp_count_reg;

    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    slot_word_t            wr_data;
    logic [SLOT_W-1:0]     rd_addr;
    slot_word_t            rd_data;
    logic [QUANTUM_W-1:0]  dec_cnt;
    logic                  issue;
    logic                  out_free;
    scan_ctl_t             scan_ctl;
    logic [SLOT_W-1:0]     best_slot;
    logic [ID_W-1:0]       best_id;
    logic [COUNT_W-1:0]    run_count;
    logic                  req_acc;

    assign req_acc  = req.valid && req.ready;
    assign issue    = scan_idx_reg < (SLOT_W + 1)'(TASK_SLOTS);
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign rd_addr  = (state_reg == S_SCAN) ? scan_idx_reg[SLOT_W-1:0] : running_slot_reg;
    assign dec_cnt  = (rd_data.counter == '0) ? '0 : rd_data.counter - QUANTUM_W'(1);

    mcts_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        scan_ctl.clear    = (state_reg == S_APPLY);
        scan_ctl.eval     = eval_vld_reg;
        scan_ctl.idx      = eval_idx_reg;
        scan_ctl.cand     = valid_reg[eval_idx_reg] && running_reg[eval_idx_reg]
                            && (rd_data.counter != '0);
        scan_ctl.in_range = 32'(eval_idx_reg) >= 32'(scan_start_reg);
    end

    mcts_scan u_scan (
        .clk       (clk),
        .ctl       (scan_ctl),
        .word      (rd_data),
        .best_slot (best_slot),
        .best_id   (best_id),
        .count     (run_count)
    );

    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        running_next      = running_reg;
        preempt_next      = preempt_reg;
        running_slot_next = running_slot_reg;
        insert_slot_next  = insert_slot_reg;
        next_id_next      = next_id_reg;
        do_pick_next      = do_pick_reg;
        created_next      = created_reg;
        wr_en             = 1'b0;
        wr_addr           = running_slot_reg;
        wr_data           = '{counter: '0, id: rd_data.id};

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                do_pick_next = 1'b0;
                created_next = '0;
                case (action_reg)
                    ACT_TICK:
                    begin
                        wr_en        = 1'b1;
                        wr_data      = '{counter: dec_cnt, id: rd_data.id};
                        do_pick_next = (dec_cnt == '0) && preempt_reg[running_slot_reg];
                    end
                    ACT_YIELD:
                    begin
                        wr_en        = 1'b1;
                        do_pick_next = 1'b1;
                    end
                    ACT_EXIT:
                    begin
                        wr_en                          = 1'b1;
                        do_pick_next                   = 1'b1;
                        running_next[running_slot_reg] = 1'b0;
                    end
                    ACT_CREATE:
                    begin
                        wr_en                          = 1'b1;
                        wr_addr                        = insert_slot_reg;
                        wr_data                        = '{counter: quantum_reg, id: next_id_reg};
                        valid_next[insert_slot_reg]    = 1'b1;
                        running_next[insert_slot_reg]  = 1'b1;
                        preempt_next[insert_slot_reg]  = 1'b1;
                        preempt_next[running_slot_reg] = 1'b1;
                        created_next                   = next_id_reg;
                        next_id_next                   = next_id_reg + ID_W'(1);
                        // slot 0 is never handed out again
                        insert_slot_next = (32'(insert_slot_reg) == TASK_SLOTS - 1)
                                           ? SLOT_W'(1) : insert_slot_reg + SLOT_W'(1);
                    end
                    ACT_PREEMPT:
                    begin
                        preempt_next[running_slot_reg] = pv_reg;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!issue && !eval_vld_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (do_pick_reg)
                    begin
                        preempt_next[running_slot_reg] = 1'b0;
                        preempt_next[best_slot]        = 1'b1;
                        running_slot_next              = best_slot;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            quantum_reg      <= QUANTUM_RESET;
            scan_start_reg   <= SCAN_RESET;
            valid_reg        <= TASK_SLOTS'(1);
            running_reg      <= TASK_SLOTS'(1);
            preempt_reg      <= '0;
            running_slot_reg <= '0;
            insert_slot_reg  <= SLOT_W'(1);
            next_id_reg      <= ID_W'(1);
            scan_idx_reg     <= '0;
            eval_vld_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            running_reg      <= running_next;
            preempt_reg      <= preempt_next;
            running_slot_reg <= running_slot_next;
            insert_slot_reg  <= insert_slot_next;
            next_id_reg      <= next_id_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUANTUM: quantum_reg    <= cfg_data[QUANTUM_W-1:0];
                    CFG_SCAN:    scan_start_reg <= cfg_data[SCAN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == S_APPLY)
            begin
                scan_idx_reg <= '0;
            end
            else if (state_reg == S_SCAN && issue)
            begin
                scan_idx_reg <= scan_idx_reg + (SLOT_W + 1)'(1);
            end
            eval_vld_reg <= (state_reg == S_SCAN) && issue;

            if (state_reg == S_FIN && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            action_reg <= req.action;
            pv_reg     <= req.preempt_value;
        end
        do_pick_reg  <= do_pick_next;
        created_reg  <= created_next;
        eval_idx_reg <= scan_idx_reg[SLOT_W-1:0];
        if (eval_vld_reg && eval_idx_reg == running_slot_reg)
        begin
            run_id_reg <= rd_data.id;
        end
        if (state_reg == S_FIN && out_free)
        begin
            rsp_slot_reg     <= do_pick_reg ? SLOT_OUT_W'(best_slot)
                                            : SLOT_OUT_W'(running_slot_reg);
            rsp_id_reg       <= do_pick_reg ? best_id : run_id_reg;
            rsp_switched_reg <= do_pick_reg && (best_slot != running_slot_reg);
            rsp_created_reg  <= created_reg;
            rsp_count_reg    <= run_count;
        end
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.current_slot   = rsp_slot_reg;
    assign rsp.current_id     = rsp_id_reg;
    assign rsp.switched       = rsp_switched_reg;
    assign rsp.created_id     = rsp_created_reg;
    assign rsp.runnable_count = rsp_count_reg;
endmodule

@@ rtl/mcts_checker.sv @@
`timescale 1ns / 1ps
module mcts_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [mcts_pkg::SLOT_OUT_W-1:0] rsp_current_slot,
    input logic [mcts_pkg::ID_W-1:0]    rsp_current_id,
    input logic                         rsp_switched,
    input logic [mcts_pkg::ID_W-1:0]    rsp_created_id,
    input logic [mcts_pkg::COUNT_W-1:0] rsp_runnable_count
);
    import mcts_pkg::*;

    logic [1:0] pend_reg;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // beats taken in but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(req_acc) - 2'(rsp_acc);
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("req still ready right after an accepted beat");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc |-> pend_reg != 2'd0)
        else $error("result delivered with no beat outstanding");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_slot)
            && $stable(rsp_current_id) && $stable(rsp_switched)
            && $stable(rsp_created_id) && $stable(rsp_runnable_count))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_runnable_count) <= TASK_SLOTS)
        else $error("runnable count above table size");

    a_switch_not_create: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_switched |-> rsp_created_id == '0)
        else $error("task switch reported together with a created id");
endmodule

bind max_counter_task_scheduler mcts_checker u_mcts_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_current_slot   (rsp.current_slot),
    .rsp_current_id     (rsp.current_id),
    .rsp_switched       (rsp.switched),
    .rsp_created_id     (rsp.created_id),
    .rsp_runnable_count (rsp.runnable_count)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import mcts_pkg::*;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic [ID_W-1:0]       id;
        logic                  switched;
        logic [ID_W-1:0]       created;
        logic [COUNT_W-1:0]    runnable;
    } sched_view_t;

    // shadow copy of the task table, advanced once per accepted request beat
    class sched_shadow;
        bit                   slot_live[TASK_SLOTS];
        bit                   slot_active[TASK_SLOTS];
        logic [QUANTUM_W-1:0] slice[TASK_SLOTS];
        bit                   may_preempt[TASK_SLOTS];
        logic [ID_W-1:0]      task_id[TASK_SLOTS];
        int                   cur_slot;
        int                   ins_slot;
        logic [ID_W-1:0]      id_next;
        logic [QUANTUM_W-1:0] quantum;
        int                   scan_from;
        sched_view_t          due[$];
        int                   errors;

        function new();
            foreach (slot_live[i])
            begin
                slot_live[i]   = 1'b0;
                slot_active[i] = 1'b0;
                slice[i]       = '0;
                may_preempt[i] = 1'b0;
                task_id[i]     = '0;
            end
            slot_live[0]   = 1'b1;
            slot_active[0] = 1'b1;
            cur_slot       = 0;
            ins_slot       = 1;
            id_next        = ID_W'(1);
            quantum        = QUANTUM_RESET;
            scan_from      = SCAN_RESET;
            errors         = 0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_QUANTUM)
                quantum = data[QUANTUM_W-1:0];
            else
                scan_from = data[SCAN_W-1:0];
        endfunction

        // lowest slot from scan_from up with the largest positive slice, falling back to slot 0
        function void reschedule();
            int best;
            int top;
            best = 0;
            top  = 0;
            for (int i = scan_from; i < TASK_SLOTS; i++)
            begin
                if (slot_live[i] && slot_active[i] && slice[i] > top)
                begin
                    top  = slice[i];
                    best = i;
                end
            end
            may_preempt[cur_slot] = 1'b0;
            cur_slot              = best;
            may_preempt[cur_slot] = 1'b1;
        endfunction

        function logic [COUNT_W-1:0] runnable_total();
            int n;
            n = 0;
            foreach (slot_live[i])
                if (slot_live[i] && slot_active[i] && slice[i] != 0)
                    n++;
            return (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
        endfunction

        function void note_action(logic [ACTION_W-1:0] act, logic pv);
            int          old;
            sched_view_t want;
            old          = cur_slot;
            want.created = '0;
            case (act)
                ACT_TICK:
                begin
                    if (slice[cur_slot] != 0)
                        slice[cur_slot]--;
                    if (slice[cur_slot] == 0 && may_preempt[cur_slot])
                        reschedule();
                end
                ACT_YIELD:
                begin
                    slice[cur_slot] = '0;
                    reschedule();
                end
                ACT_EXIT:
                begin
                    slot_active[cur_slot] = 1'b0;
                    slice[cur_slot]       = '0;
                    reschedule();
                end
                ACT_CREATE:
                begin
                    slot_live[ins_slot]   = 1'b1;
                    slot_active[ins_slot] = 1'b1;
                    slice[ins_slot]       = quantum;
                    may_preempt[ins_slot] = 1'b1;
                    task_id[ins_slot]     = id_next;
                    want.created          = id_next;
                    id_next               = id_next + 1'b1;
                    ins_slot              = (ins_slot + 1 >= TASK_SLOTS) ? 1 : ins_slot + 1;
                    may_preempt[cur_slot] = 1'b1;
                end
                ACT_PREEMPT:
                    may_preempt[cur_slot] = pv;
                default:
                begin
                end
            endcase
            want.slot     = SLOT_OUT_W'(cur_slot);
            want.id       = task_id[cur_slot];
            want.switched = (cur_slot != old);
            want.runnable = runnable_total();
            due.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(sched_view_t got);
            sched_view_t want;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, expected none, actual slot %0d id %0d",
                         $time, got.slot, got.id);
                return;
            end
            want = due.pop_front();
            compare_field("current_slot", want.slot, got.slot);
            compare_field("current_id", want.id, got.id);
            compare_field("switched", want.switched, got.switched);
            compare_field("created_id", want.created, got.created);
            compare_field("runnable_count", want.runnable, got.runnable);
        endfunction
    endclass

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 222;
    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = ACT_PREEMPT + 1'b1;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = '1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct;
    int recv_stall_pct;
    int cycles;

    sched_shadow shadow = new();

    mcts_in_if  req_if ();
    mcts_out_if rsp_if ();

    max_counter_task_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_action(input logic [ACTION_W-1:0] act, input logic pv);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.action        <= act;
        req_if.preempt_value <= pv;
        do
            @(posedge clk);
        while (!req_if.ready);
        shadow.note_action(act, pv);
    endtask

    // drop valid and wait until every result is back and the block takes requests
    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (shadow.due.size() != 0 || !req_if.ready)
            @(posedge clk);
    endtask

    task automatic write_regs(input logic [QUANTUM_W-1:0] q, input logic [SCAN_W-1:0] s);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_QUANTUM;
        cfg_data  <= CFG_DATA_W'(q);
        @(posedge clk);
        shadow.set_config(CFG_QUANTUM, CFG_DATA_W'(q));
        cfg_index <= CFG_SCAN;
        cfg_data  <= CFG_DATA_W'(s);
        @(posedge clk);
        shadow.set_config(CFG_SCAN, CFG_DATA_W'(s));
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [ACTION_W-1:0] pick_action(int create_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < create_pct)
            return ACT_CREATE;
        r = $urandom_range(0, 99);
        if (r < 50)
            return ACT_TICK;
        if (r < 64)
            return ACT_YIELD;
        if (r < 76)
            return ACT_EXIT;
        if (r < 95)
            return ACT_PREEMPT;
        return ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    endfunction

    // result side: check accepted beats, then decide ready for the next edge
    initial
    begin
        sched_view_t seen;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                seen.slot     = rsp_if.current_slot;
                seen.id       = rsp_if.current_id;
                seen.switched = rsp_if.switched;
                seen.created  = rsp_if.created_id;
                seen.runnable = rsp_if.runnable_count;
                shadow.check_report(seen);
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("max_counter_task_scheduler test failed");
        $finish;
    end

    initial
    begin
        logic [QUANTUM_W-1:0] q;
        logic [SCAN_W-1:0]    s;
        int                   create_pct;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_QUANTUM;
        cfg_data             <= '0;
        req_if.valid         <= 1'b0;
        req_if.action        <= ACT_TICK;
        req_if.preempt_value <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk at the reset settings
        send_action(ACT_TICK, 1'b1);     // counter already 0, no preempt: nothing moves
        send_action(ACT_PREEMPT, 1'b1);
        send_action(ACT_TICK, 1'b0);     // expires with preempt on, empty scan keeps slot 0
        send_action(ACT_CREATE, 1'b0);   // slot 1 sits below scan start
        send_action(ACT_CREATE, 1'b1);
        send_action(ACT_CREATE, 1'b0);
        send_action(ACT_YIELD, 1'b0);    // ties go to the lowest slot
        send_action(ACT_TICK, 1'b0);
        send_action(ACT_TICK, 1'b1);     // expires and switches
        send_action(ACT_PREEMPT, 1'b0);
        send_action(ACT_TICK, 1'b0);
        send_action(ACT_TICK, 1'b0);     // expires with preempt off: stays put
        send_action(ACT_TICK, 1'b1);     // saturates at zero
        send_action(ACT_PREEMPT, 1'b1);
        send_action(ACT_EXIT, 1'b0);     // zombie, back to slot 0
        send_action(ACT_EXIT, 1'b1);     // slot 0 itself becomes a zombie
        send_action(ACT_YIELD, 1'b1);
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
        begin
            send_action(ACTION_W'(a), 1'b0);
            send_action(ACTION_W'(a), 1'b1);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    q = QUANTUM_W'(1);
                    s = '0;
                end
                1:
                begin
                    q = '1;
                    s = '1;
                end
                2:
                begin
                    q = QUANTUM_W'($urandom_range(1, 255));
                    s = SCAN_W'($urandom_range(0, 63));
                end
                3:
                begin
                    q = QUANTUM_W'($urandom_range(1, 4));
                    s = SCAN_W'(1);
                end
                4:
                begin
                    q = '1;
                    s = '0;
                end
                default:
                begin
                    q = QUANTUM_W'(1);
                    s = '1;
                end
            endcase
            write_regs(q, s);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 60;
                end
                default:
                begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                end
            endcase
            // one phase leans on creates so the insert slot wraps over live tasks
            create_pct = (ph == 3) ? 45 : 20;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_action(pick_action(create_pct), 1'($urandom_range(0, 1)));
        end

        req_if.valid <= 1'b0;
        while (shadow.due.size() != 0)
            @(posedge clk);
        repeat (TASK_SLOTS + 8) @(posedge clk);

        if (shadow.errors == 0 && shadow.due.size() == 0)
            $display("max_counter_task_scheduler test passed");
        else
            $display("max_counter_task_scheduler test failed");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/mcts_pkg.sv
rtl/mcts_in_if.sv
rtl/mcts_out_if.sv
rtl/mcts_table.sv
rtl/mcts_scan.sv
rtl/max_counter_task_scheduler.sv
rtl/mcts_checker.sv
test/tb.sv
